// ===== sv/cpor_pkg.sv =====
`default_nettype none
package cpor_pkg;

   localparam int CoordWidth = 32;
   localparam int CwEff      = (CoordWidth < 32) ? CoordWidth : 32;

   localparam int SqrtDepth  = 33;
   localparam int DivDepth   = 31;

   // pipeline positions of the shared side line
   localparam int StgSqIn    = 2;
   localparam int StgDist    = StgSqIn + SqrtDepth + 1;
   localparam int StgDelta   = StgDist + 1;
   localparam int StgProd    = StgDelta + 1;
   localparam int StgShift   = StgProd + DivDepth + 1;
   localparam int StgOut     = StgShift + DivDepth + 1;
   localparam int PipeDepth  = StgOut + 1;

   localparam logic [15:0] CoeffReset = 16'd58982;

   localparam logic signed [35:0] CoordMax = (36'sd1 <<< (CwEff - 1)) - 36'sd1;
   localparam logic signed [35:0] CoordMin = -CoordMax - 36'sd1;

   typedef struct packed {
      logic signed [33:0] ax;
      logic signed [33:0] ay;
      logic signed [33:0] bx;
      logic signed [33:0] by;
      logic [30:0]        da;
      logic [30:0]        db;
      logic               sgx;
      logic               sgy;
      logic [32:0]        mx;
      logic [32:0]        my;
      logic [31:0]        sumd;
      logic               coin;
      logic [63:0]        sqx;
      logic [63:0]        sqy;
      logic [64:0]        rad;
      logic [32:0]        dist_val;
      logic               over;
      logic [32:0]        ov2;
      logic [30:0]        delta;
      logic [61:0]        pa;
      logic [61:0]        pb;
      logic [63:0]        pxa;
      logic [63:0]        pya;
      logic [63:0]        pxb;
      logic [63:0]        pyb;
      logic [31:0]        nax;
      logic [31:0]        nay;
      logic [31:0]        nbx;
      logic [31:0]        nby;
   } side_type;

   // read a coordinate at the coordinate width
   function automatic logic signed [33:0] sext_coord(input logic [31:0] v);
      logic signed [31:0] t;
      t = $signed(v << (32 - CwEff)) >>> (32 - CwEff);
      return 34'(t);
   endfunction

   function automatic logic [31:0] sat_coord(input logic signed [35:0] v);
      logic signed [35:0] r;
      if (v > CoordMax) begin
         r = CoordMax;
      end else if (v < CoordMin) begin
         r = CoordMin;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/cpor_sqrt.sv =====
`default_nettype none
module cpor_sqrt (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [64:0] radicand,
   output logic      [32:0] root
);
   import cpor_pkg::*;

   logic [65:0] rad_ff  [SqrtDepth];
   logic [34:0] rem_ff  [SqrtDepth];
   logic [32:0] root_ff [SqrtDepth];
   logic [65:0] rad_in  [SqrtDepth];
   logic [34:0] rem_in  [SqrtDepth];
   logic [32:0] root_in [SqrtDepth];

   // one result bit per stage, most significant pair first
   for (genvar j = 0; j < SqrtDepth; j++) begin : g_stage
      localparam int K = SqrtDepth - 1 - j;
      logic [65:0] rad_prev;
      logic [34:0] rem_prev;
      logic [32:0] root_prev;
      logic [36:0] rem_ext;
      logic [36:0] trial;
      if (j == 0) begin : g_first
         assign rad_prev  = {1'b0, radicand};
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end
      assign rem_ext = {rem_prev, rad_prev[2*K+1 -: 2]};
      assign trial   = {2'b00, root_prev, 2'b01};
      always_comb begin
         rad_in[j] = rad_prev;
         if (rem_ext >= trial) begin
            rem_in[j]  = 35'(rem_ext - trial);
            root_in[j] = {root_prev[31:0], 1'b1};
         end else begin
            rem_in[j]  = rem_ext[34:0];
            root_in[j] = {root_prev[31:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[j]  <= rad_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign root = root_ff[SqrtDepth-1];

endmodule
`default_nettype wire

// ===== sv/cpor_div.sv =====
`default_nettype none
module cpor_div (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [63:0] dividend,
   input  wire logic [32:0] divisor,
   output logic      [30:0] quotient
);
   import cpor_pkg::*;

   logic [63:0] rem_ff [DivDepth];
   logic [32:0] dsr_ff [DivDepth];
   logic [30:0] quo_ff [DivDepth];
   logic [63:0] rem_in [DivDepth];
   logic [32:0] dsr_in [DivDepth];
   logic [30:0] quo_in [DivDepth];

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < DivDepth; j++) begin : g_stage
      localparam int B = DivDepth - 1 - j;
      logic [63:0] rem_prev;
      logic [32:0] dsr_prev;
      logic [30:0] quo_prev;
      logic [63:0] trial;
      if (j == 0) begin : g_first
         assign rem_prev = dividend;
         assign dsr_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign dsr_prev = dsr_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end
      assign trial = {31'b0, dsr_prev} << B;
      always_comb begin
         dsr_in[j] = dsr_prev;
         if (rem_prev >= trial) begin
            rem_in[j] = rem_prev - trial;
            quo_in[j] = quo_prev | (31'd1 << B);
         end else begin
            rem_in[j] = rem_prev;
            quo_in[j] = quo_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= rem_in[j];
            dsr_ff[j] <= dsr_in[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quotient = quo_ff[DivDepth-1];

endmodule
`default_nettype wire

// ===== sv/circle_pair_overlap_resolve.sv =====
// Circle pair overlap resolver.
// Request beat: two circle centres (signed Q16.16) and two diameters
// (unsigned Q15.16) on req_*, valid/ready. Response beat: both corrected
// centres, saturated, plus the overlapped and coincident flags on rsp_*.
// csr_wr_en/csr_wr_data write the response coefficient (unsigned Q0.16);
// write it only while no beat is in flight.
// The pipeline has 103 register stages: one stage each for differences,
// squares and their sum, 33 stages of the root (one result bit each),
// three for overlap, scale and products, 31 stages of the diameter-share
// divider, one for the normal products and 31 stages of the divider by
// distance, then the update stage.
// Throughput is one beat per cycle while the receiver does not stall;
// every stage moves on one common advance strobe, which is high whenever
// the output register is empty or being taken.
// Reset empties the pipeline (all valid bits cleared) and loads the
// coefficient with its default of about 0.9.
// When the receiver stalls with a response waiting, the whole pipeline
// holds and req_ready drops; no beat is lost or repeated.
`default_nettype none
module circle_pair_overlap_resolve (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_a_pos_x,
   input  wire logic [31:0] req_a_pos_y,
   input  wire logic [30:0] req_a_diameter,
   input  wire logic [31:0] req_b_pos_x,
   input  wire logic [31:0] req_b_pos_y,
   input  wire logic [30:0] req_b_diameter,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_a_new_x,
   output logic [31:0]      rsp_a_new_y,
   output logic [31:0]      rsp_b_new_x,
   output logic [31:0]      rsp_b_new_y,
   output logic             rsp_overlapped,
   output logic             rsp_coincident
);
   import cpor_pkg::*;

   logic [15:0] coeff_ff;
   logic [15:0] coeff_in;
   logic        valid_ff [PipeDepth];
   logic        valid_in [PipeDepth];
   side_type    pipe_ff  [PipeDepth];
   side_type    pipe_in  [PipeDepth];
   logic        adv;

   logic [32:0] dist_root;
   logic [30:0] sa_q;
   logic [30:0] sb_q;
   logic [30:0] qxa;
   logic [30:0] qya;
   logic [30:0] qxb;
   logic [30:0] qyb;

   // advance everything together; hold while a response waits
   assign adv       = !valid_ff[StgOut] || rsp_ready;
   assign req_ready = adv;

   assign coeff_in = csr_wr_en ? csr_wr_data : coeff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= CoeffReset;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   // distance root of the summed squares
   cpor_sqrt u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (pipe_ff[StgSqIn].rad),
      .root     (dist_root)
   );

   // diameter shares: delta * d_self / (da + db)
   cpor_div u_div_sa (
      .clock    (clock),
      .enable   (adv),
      .dividend ({2'b00, pipe_ff[StgProd].pa}),
      .divisor  ({1'b0, pipe_ff[StgProd].sumd}),
      .quotient (sa_q)
   );

   cpor_div u_div_sb (
      .clock    (clock),
      .enable   (adv),
      .dividend ({2'b00, pipe_ff[StgProd].pb}),
      .divisor  ({1'b0, pipe_ff[StgProd].sumd}),
      .quotient (sb_q)
   );

   // normal components: |d| * share / dist
   cpor_div u_div_xa (
      .clock    (clock),
      .enable   (adv),
      .dividend (pipe_ff[StgShift].pxa),
      .divisor  (pipe_ff[StgShift].dist_val),
      .quotient (qxa)
   );

   cpor_div u_div_ya (
      .clock    (clock),
      .enable   (adv),
      .dividend (pipe_ff[StgShift].pya),
      .divisor  (pipe_ff[StgShift].dist_val),
      .quotient (qya)
   );

   cpor_div u_div_xb (
      .clock    (clock),
      .enable   (adv),
      .dividend (pipe_ff[StgShift].pxb),
      .divisor  (pipe_ff[StgShift].dist_val),
      .quotient (qxb)
   );

   cpor_div u_div_yb (
      .clock    (clock),
      .enable   (adv),
      .dividend (pipe_ff[StgShift].pyb),
      .divisor  (pipe_ff[StgShift].dist_val),
      .quotient (qyb)
   );

   always_comb begin
      side_type           s0;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic [65:0]        sq_x;
      logic [65:0]        sq_y;
      logic signed [34:0] ov2;
      logic [48:0]        scaled;
      logic               move;
      logic signed [35:0] sxa;
      logic signed [35:0] sya;
      logic signed [35:0] sxb;
      logic signed [35:0] syb;

      // default: carry the side line forward one stage
      valid_in[0] = req_valid;
      for (int i = 1; i < PipeDepth; i++) begin
         valid_in[i] = valid_ff[i-1];
         pipe_in[i]  = pipe_ff[i-1];
      end

      // entry: read coordinates, take differences and magnitudes
      s0      = '0;
      s0.ax   = sext_coord(req_a_pos_x);
      s0.ay   = sext_coord(req_a_pos_y);
      s0.bx   = sext_coord(req_b_pos_x);
      s0.by   = sext_coord(req_b_pos_y);
      s0.da   = req_a_diameter;
      s0.db   = req_b_diameter;
      dx      = s0.bx - s0.ax;
      dy      = s0.by - s0.ay;
      s0.sgx  = dx[33];
      s0.sgy  = dy[33];
      s0.mx   = dx[33] ? 33'(-dx) : dx[32:0];
      s0.my   = dy[33] ? 33'(-dy) : dy[32:0];
      s0.sumd = {1'b0, req_a_diameter} + {1'b0, req_b_diameter};
      s0.coin = (dx == '0) && (dy == '0);
      pipe_in[0] = s0;

      // squares, then their 65-bit sum
      sq_x = {33'b0, pipe_ff[0].mx} * {33'b0, pipe_ff[0].mx};
      sq_y = {33'b0, pipe_ff[0].my} * {33'b0, pipe_ff[0].my};
      pipe_in[1].sqx = sq_x[63:0];
      pipe_in[1].sqy = sq_y[63:0];

      pipe_in[StgSqIn].rad = {1'b0, pipe_ff[1].sqx} + {1'b0, pipe_ff[1].sqy};

      // twice the overlap: sum of diameters less twice the distance
      ov2 = $signed({3'b000, pipe_ff[StgDist-1].sumd}) -
            $signed({1'b0, dist_root, 1'b0});
      pipe_in[StgDist].dist_val = dist_root;
      pipe_in[StgDist].over     = !ov2[34] && (ov2 != '0);
      pipe_in[StgDist].ov2      = ov2[32:0];

      // half coefficient times overlap
      scaled = {33'b0, coeff_ff} * {16'b0, pipe_ff[StgDist].ov2};
      pipe_in[StgDelta].delta = scaled[48:18];

      pipe_in[StgProd].pa = {31'b0, pipe_ff[StgDelta].delta} *
                            {31'b0, pipe_ff[StgDelta].da};
      pipe_in[StgProd].pb = {31'b0, pipe_ff[StgDelta].delta} *
                            {31'b0, pipe_ff[StgDelta].db};

      pipe_in[StgShift].pxa = {31'b0, pipe_ff[StgShift-1].mx} * {33'b0, sa_q};
      pipe_in[StgShift].pya = {31'b0, pipe_ff[StgShift-1].my} * {33'b0, sa_q};
      pipe_in[StgShift].pxb = {31'b0, pipe_ff[StgShift-1].mx} * {33'b0, sb_q};
      pipe_in[StgShift].pyb = {31'b0, pipe_ff[StgShift-1].my} * {33'b0, sb_q};

      // update: push a back and b forward along the normal, saturate
      move = pipe_ff[StgOut-1].over && !pipe_ff[StgOut-1].coin &&
             (pipe_ff[StgOut-1].sumd != '0) && (pipe_ff[StgOut-1].dist_val != '0);
      sxa  = pipe_ff[StgOut-1].sgx ? -$signed({5'b0, qxa}) : $signed({5'b0, qxa});
      sya  = pipe_ff[StgOut-1].sgy ? -$signed({5'b0, qya}) : $signed({5'b0, qya});
      sxb  = pipe_ff[StgOut-1].sgx ? -$signed({5'b0, qxb}) : $signed({5'b0, qxb});
      syb  = pipe_ff[StgOut-1].sgy ? -$signed({5'b0, qyb}) : $signed({5'b0, qyb});
      if (move) begin
         pipe_in[StgOut].nax = sat_coord(36'(pipe_ff[StgOut-1].ax) - sxa);
         pipe_in[StgOut].nay = sat_coord(36'(pipe_ff[StgOut-1].ay) - sya);
         pipe_in[StgOut].nbx = sat_coord(36'(pipe_ff[StgOut-1].bx) + sxb);
         pipe_in[StgOut].nby = sat_coord(36'(pipe_ff[StgOut-1].by) + syb);
      end else begin
         pipe_in[StgOut].nax = pipe_ff[StgOut-1].ax[31:0];
         pipe_in[StgOut].nay = pipe_ff[StgOut-1].ay[31:0];
         pipe_in[StgOut].nbx = pipe_ff[StgOut-1].bx[31:0];
         pipe_in[StgOut].nby = pipe_ff[StgOut-1].by[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PipeDepth; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         for (int i = 0; i < PipeDepth; i++) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < PipeDepth; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign rsp_valid      = valid_ff[StgOut];
   assign rsp_a_new_x    = pipe_ff[StgOut].nax;
   assign rsp_a_new_y    = pipe_ff[StgOut].nay;
   assign rsp_b_new_x    = pipe_ff[StgOut].nbx;
   assign rsp_b_new_y    = pipe_ff[StgOut].nby;
   assign rsp_overlapped = pipe_ff[StgOut].over;
   assign rsp_coincident = pipe_ff[StgOut].coin;

   // a pipeline just out of reset carries no response
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // coincident centres pass through unchanged
   a_coin_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_coincident) |->
         (rsp_a_new_x == pipe_ff[StgOut].ax[31:0]) &&
         (rsp_b_new_y == pipe_ff[StgOut].by[31:0]))
      else $error("coincident pair was moved");

   // separated circles are never moved
   a_no_overlap_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_overlapped) |->
         (rsp_a_new_y == pipe_ff[StgOut].ay[31:0]) &&
         (rsp_b_new_x == pipe_ff[StgOut].bx[31:0]))
      else $error("non-overlapping pair was moved");

   // a stalled response holds the request side back
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

endmodule
`default_nettype wire

// ===== tb/circle_pair_overlap_resolve_tb.sv =====
`default_nettype none
module circle_pair_overlap_resolve_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency    = 103;
   localparam int DrainWait  = Latency + 10;
   localparam int StallLimit = 5000;

   // one predicted response beat
   typedef struct {
      logic [31:0] a_x;
      logic [31:0] a_y;
      logic [31:0] b_x;
      logic [31:0] b_y;
      logic        over;
      logic        coin;
   } moved_pair_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_a_pos_x;
   logic [31:0] req_a_pos_y;
   logic [30:0] req_a_diameter;
   logic [31:0] req_b_pos_x;
   logic [31:0] req_b_pos_y;
   logic [30:0] req_b_diameter;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_a_new_x;
   logic [31:0] rsp_a_new_y;
   logic [31:0] rsp_b_new_x;
   logic [31:0] rsp_b_new_y;
   logic        rsp_overlapped;
   logic        rsp_coincident;

   // the model's own copy of the response coefficient
   logic [15:0] coeff_shadow;
   moved_pair_type pending_moves[$];
   int unsigned errors;
   int unsigned beats_in;
   int unsigned beats_out;
   int unsigned overlaps_seen;
   int unsigned coincident_seen;
   int unsigned stall_count;
   // high while neither side may idle
   logic        calm;

   circle_pair_overlap_resolve i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_a_pos_x    (req_a_pos_x),
      .req_a_pos_y    (req_a_pos_y),
      .req_a_diameter (req_a_diameter),
      .req_b_pos_x    (req_b_pos_x),
      .req_b_pos_y    (req_b_pos_y),
      .req_b_diameter (req_b_diameter),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_a_new_x    (rsp_a_new_x),
      .rsp_a_new_y    (rsp_a_new_y),
      .rsp_b_new_x    (rsp_b_new_x),
      .rsp_b_new_y    (rsp_b_new_y),
      .rsp_overlapped (rsp_overlapped),
      .rsp_coincident (rsp_coincident)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // floor square root of a sum of two squares, up to 66 bits wide
   function automatic logic [32:0] floor_root(input logic [65:0] v);
      logic [67:0] rem;
      logic [67:0] root;
      logic [67:0] trial;
      rem  = '0;
      root = '0;
      for (int k = 32; k >= 0; k--) begin
         rem   = (rem << 2) | 68'(v[2*k +: 2]);
         trial = (root << 2) | 68'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 68'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[32:0];
   endfunction

   // component of a push along the normal, truncated toward zero
   function automatic longint normal_part(input longint d, input longint unsigned s,
                                          input longint unsigned dist_val);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q   = (mag * s) / dist_val;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [31:0] clamp_coord(input longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic moved_pair_type resolve_pair(input logic [15:0] coeff,
         input logic [31:0] ax_in, input logic [31:0] ay_in, input logic [30:0] da_in,
         input logic [31:0] bx_in, input logic [31:0] by_in, input logic [30:0] db_in);
      moved_pair_type r;
      longint ax, ay, bx, by, dx, dy, ov2;
      longint unsigned mx, my, dist_val, sumd, delta, sa, sb;
      logic [65:0] sq;
      ax   = longint'($signed(ax_in));
      ay   = longint'($signed(ay_in));
      bx   = longint'($signed(bx_in));
      by   = longint'($signed(by_in));
      dx   = bx - ax;
      dy   = by - ay;
      mx   = (dx < 0) ? longint'(-dx) : longint'(dx);
      my   = (dy < 0) ? longint'(-dy) : longint'(dy);
      sq   = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
      dist_val = 64'(floor_root(sq));
      sumd = 64'(da_in) + 64'(db_in);
      ov2  = longint'(sumd) - 2 * longint'(dist_val);
      r.over = ov2 > 0;
      r.coin = (dx == 0) && (dy == 0);
      r.a_x  = ax_in;
      r.a_y  = ay_in;
      r.b_x  = bx_in;
      r.b_y  = by_in;
      if (r.over && !r.coin && sumd != 0 && dist_val != 0) begin
         delta = (64'(coeff) * longint'(ov2)) >> 18;
         sa    = (delta * 64'(da_in)) / sumd;
         sb    = (delta * 64'(db_in)) / sumd;
         r.a_x = clamp_coord(ax - normal_part(dx, sa, dist_val));
         r.a_y = clamp_coord(ay - normal_part(dy, sa, dist_val));
         r.b_x = clamp_coord(bx + normal_part(dx, sb, dist_val));
         r.b_y = clamp_coord(by + normal_part(dy, sb, dist_val));
      end
      return r;
   endfunction

   // offer one pair; return once the beat is taken
   task automatic send_pair(input logic [31:0] ax, input logic [31:0] ay,
                            input logic [30:0] da, input logic [31:0] bx,
                            input logic [31:0] by, input logic [30:0] db);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_a_pos_x    <= ax;
      req_a_pos_y    <= ay;
      req_a_diameter <= da;
      req_b_pos_x    <= bx;
      req_b_pos_y    <= by;
      req_b_diameter <= db;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_moves.push_back(resolve_pair(coeff_shadow, ax, ay, da, bx, by, db));
      beats_in++;
   endtask

   // hold the request side low and let every beat in flight come out
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_coeff(input logic [15:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      coeff_shadow = value;
   endtask

   // pair that may overlap: b sits near a, within a span of span_bits bits
   task automatic send_overlapping(input int unsigned span_bits);
      logic [31:0] cx, cy, ox, oy;
      logic [30:0] da, db;
      cx = $urandom();
      cy = $urandom();
      da = 31'($urandom()) >> $urandom_range(30, 0);
      db = 31'($urandom()) >> $urandom_range(30, 0);
      ox = 32'($signed(32'($urandom())) >>> (32 - span_bits));
      oy = 32'($signed(32'($urandom())) >>> (32 - span_bits));
      if ($urandom_range(19) == 0) begin
         ox = '0;
         oy = '0;
      end
      send_pair(cx, cy, da, cx + ox, cy + oy, db);
   endtask

   task automatic test_directed;
      // every field at both extremes, both flags, saturation at both rails
      send_pair(32'h0, 32'h0, 31'h0, 32'h0, 32'h0, 31'h0);
      send_pair(32'h0001_0000, 32'h0, 31'h0002_0000, 32'h0001_0000, 32'h0, 31'h0002_0000);
      send_pair(32'h0, 32'h0, 31'h0001_0000, 32'h0010_0000, 32'h0, 31'h0001_0000);
      send_pair(32'h0, 32'h0, 31'h0004_0000, 32'h0002_0000, 32'h0, 31'h0);
      send_pair(32'h0, 32'h0, 31'h0004_0000, 32'h0004_0000, 32'h0, 31'h0004_0000);
      send_pair(32'h0, 32'h0, 31'h0004_0000, 32'h0, 32'h0003_0000, 31'h0004_0000);
      send_pair(32'h0, 32'h0, 31'h7fff_ffff, 32'hfffe_0000, 32'hfffe_0000, 31'h7fff_ffff);
      send_pair(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
                32'h8000_0100, 32'h8000_0100, 31'h7fff_ffff);
      send_pair(32'h7fff_ff00, 32'h7fff_ff00, 31'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
      send_pair(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
      send_pair(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
      send_pair(32'hffff_ffff, 32'hffff_ffff, 31'h1, 32'h0, 32'h0, 31'h2);
      send_pair(32'h1234_5678, 32'h9abc_def0, 31'h7fff_ffff,
                32'h1234_5678, 32'h9abc_def0, 31'h7fff_ffff);
      send_pair(32'h0, 32'h0, 31'h0, 32'h0, 32'h0, 31'h7fff_ffff);
      send_pair(32'h0, 32'h0, 31'h7fff_ffff, 32'h0000_0001, 32'h0, 31'h0);
   endtask

   task automatic test_random_mix(input int unsigned beats);
      for (int i = 0; i < beats; i++) begin
         if ($urandom_range(9) < 8) begin
            // mostly small spans so the push is well defined
            send_overlapping(($urandom_range(9) == 0) ? 32 : $urandom_range(28, 4));
         end else begin
            send_pair($urandom(), $urandom(), 31'($urandom()),
                      $urandom(), $urandom(), 31'($urandom()));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
         errors++;
      end
   endtask

   // response side: random backpressure, scoreboard and stall watchdog
   always @(posedge clock) begin
      moved_pair_type want;
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (pending_moves.size() == 0) begin
               $display("%0t unexpected response beat, expected none actual %h %h %h %h",
                        $realtime, rsp_a_new_x, rsp_a_new_y, rsp_b_new_x, rsp_b_new_y);
               errors++;
            end else begin
               want = pending_moves.pop_front();
               check_field("a_new_x", want.a_x, rsp_a_new_x);
               check_field("a_new_y", want.a_y, rsp_a_new_y);
               check_field("b_new_x", want.b_x, rsp_b_new_x);
               check_field("b_new_y", want.b_y, rsp_b_new_y);
               check_field("overlapped", 32'(want.over), 32'(rsp_overlapped));
               check_field("coincident", 32'(want.coin), 32'(rsp_coincident));
               overlaps_seen   += want.over;
               coincident_seen += want.coin;
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            stall_count <= 0;
         end else if (stall_count >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   initial begin
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_valid    <= 1'b0;
      req_a_pos_x  <= '0;
      req_a_pos_y  <= '0;
      req_a_diameter <= '0;
      req_b_pos_x  <= '0;
      req_b_pos_y  <= '0;
      req_b_diameter <= '0;
      rsp_ready    <= 1'b0;
      calm         = 1'b0;
      coeff_shadow = 16'd58982;
      errors = 0;
      beats_in = 0;
      beats_out = 0;
      overlaps_seen = 0;
      coincident_seen = 0;
      stall_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default coefficient straight out of reset
      test_directed();
      test_random_mix(250);
      write_coeff(16'd0);
      test_directed();
      test_random_mix(150);
      write_coeff(16'hffff);
      test_random_mix(200);
      // long stretch with no idling on either side
      calm = 1'b1;
      test_random_mix(200);
      calm = 1'b0;
      for (int p = 0; p < 3; p++) begin
         write_coeff(16'($urandom()));
         test_random_mix(90);
      end
      write_coeff(16'd58982);
      test_random_mix(30);
      drain();

      $display("%0d pairs sent, %0d responses checked, %0d overlapping, %0d coincident,",
               beats_in, beats_out, overlaps_seen, coincident_seen);
      $display("coefficient swept over zero, full scale, reset value and random values");
      if (errors == 0 && pending_moves.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== circle_pair_overlap_resolve.f =====
sv/cpor_pkg.sv
sv/cpor_sqrt.sv
sv/cpor_div.sv
sv/circle_pair_overlap_resolve.sv
tb/circle_pair_overlap_resolve_tb.sv
